### design/xcsfp_pkg.sv
// shared types and constants of the xor-checked serial frame parser
package xcsfp_pkg;

	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;

	// register byte addresses
	localparam logic [ADDR_W-1:0] REG_HEARTBEAT_CODE = 3'd0;

	// frame header bytes
	localparam logic [7:0] HDR_FIRST  = 8'h24;
	localparam logic [7:0] HDR_SECOND = 8'h52;

	localparam logic [7:0] HEARTBEAT_RESET = 8'd100;
	localparam logic [7:0] HEARTBEAT_LEN   = 8'd4;

	// result status codes
	typedef enum logic [1:0] {
		ST_NONE    = 2'd0,
		ST_PAYLOAD = 2'd1,
		ST_GOOD    = 2'd2,
		ST_BAD     = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       buffer_start;
	} in_word_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  command;
		logic [7:0]  length;
		logic [7:0]  byte_index;
		logic [7:0]  payload_byte;
		logic        heartbeat_valid;
		logic [31:0] heartbeat_word;
	} out_word_t;

endpackage

### design/xcsfp_in_if.sv
// valid/ready channel carrying one received byte word
interface xcsfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       buffer_start;

	modport source (output valid, output rx_byte, output buffer_start, input ready);
	modport sink (input valid, input rx_byte, input buffer_start, output ready);
endinterface

### design/xcsfp_out_if.sv
// valid/ready channel carrying one parser result word
interface xcsfp_out_if;
	logic                  valid;
	logic                  ready;
	xcsfp_pkg::status_t    status;
	logic [7:0]            command;
	logic [7:0]            length;
	logic [7:0]            byte_index;
	logic [7:0]            payload_byte;
	logic                  heartbeat_valid;
	logic [31:0]           heartbeat_word;

	modport source (
		output valid, output status, output command, output length,
		output byte_index, output payload_byte, output heartbeat_valid,
		output heartbeat_word, input ready
	);
	modport sink (
		input valid, input status, input command, input length,
		input byte_index, input payload_byte, input heartbeat_valid,
		input heartbeat_word, output ready
	);
endinterface

### design/xor_checked_serial_frame_parser.sv
// xor-checked serial frame parser top level with apb register port
// output: a result word is registered when its byte word is accepted
// throughput: one byte word per cycle while each result is taken as it comes; the output
//   register refills in the same cycle its result is taken
// reset: arst_n clears the parser to hunting, all frame fields to zero, the
//   heartbeat code to 100 and empties the output register
module xor_checked_serial_frame_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [xcsfp_pkg::ADDR_W-1:0]      paddr,
	input  logic [xcsfp_pkg::DATA_W-1:0]      pwdata,
	output logic [xcsfp_pkg::DATA_W-1:0]      prdata,
	output logic                              pready,
	xcsfp_in_if.sink                          rx,
	xcsfp_out_if.source                       res
);

	// parser phase codes
	localparam logic [2:0] PH_HUNT   = 3'd0;
	localparam logic [2:0] PH_DOLLAR = 3'd1;
	localparam logic [2:0] PH_R      = 3'd2;
	localparam logic [2:0] PH_CMD    = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;

	// configuration register
	logic [7:0] hb_code_q;

	// parser state
	logic [2:0]  phase_q;
	logic [7:0]  xor_q;
	logic [7:0]  count_q;
	logic [7:0]  cmd_q;
	logic [7:0]  len_q;
	logic [31:0] first_word_q;

	// output register
	logic                 out_valid_q;
	xcsfp_pkg::out_word_t out_q;

	logic                 take;
	logic                 cfg_wr;
	logic [2:0]           phase_d;
	logic [7:0]           xor_d;
	logic [7:0]           count_d;
	logic [7:0]           cmd_d;
	logic [7:0]           len_d;
	logic [31:0]          first_word_d;
	xcsfp_pkg::out_word_t out_d;

	// apb port: zero wait states, single register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		if (paddr == xcsfp_pkg::REG_HEARTBEAT_CODE) begin
			prdata = {{(xcsfp_pkg::DATA_W-8){1'b0}}, hb_code_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hb_code_q <= xcsfp_pkg::HEARTBEAT_RESET;
		end else if (cfg_wr && paddr == xcsfp_pkg::REG_HEARTBEAT_CODE) begin
			hb_code_q <= pwdata[7:0];
		end
	end

	// a new byte word enters whenever the output register is free or draining
	assign rx.ready = !out_valid_q || res.ready;
	assign take     = rx.valid && rx.ready;

	// next state and result for the byte word at the input
	always_comb begin
		logic [2:0] ph;
		logic [7:0] b;
		ph = rx.buffer_start ? PH_HUNT : phase_q;
		b  = rx.rx_byte;

		// start flag clears phase, running xor and payload count only
		phase_d      = ph;
		xor_d        = rx.buffer_start ? 8'd0 : xor_q;
		count_d      = rx.buffer_start ? 8'd0 : count_q;
		cmd_d        = cmd_q;
		len_d        = len_q;
		first_word_d = first_word_q;

		out_d.status          = xcsfp_pkg::ST_NONE;
		out_d.byte_index      = 8'd0;
		out_d.payload_byte    = 8'd0;
		out_d.heartbeat_valid = 1'b0;
		out_d.heartbeat_word  = 32'd0;

		unique case (ph)
			PH_HUNT: begin
				if (b == xcsfp_pkg::HDR_FIRST) begin
					phase_d = PH_DOLLAR;
				end
			end
			PH_DOLLAR: begin
				// a broken header drops the byte, it is not a new dollar sign
				if (b == xcsfp_pkg::HDR_SECOND) begin
					phase_d = PH_R;
					xor_d   = 8'd0;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_R: begin
				// command byte starts a fresh heartbeat word
				cmd_d        = b;
				xor_d        = xor_d ^ b;
				count_d      = 8'd0;
				first_word_d = 32'd0;
				phase_d      = PH_CMD;
			end
			PH_CMD: begin
				len_d   = b;
				xor_d   = xor_d ^ b;
				count_d = 8'd0;
				phase_d = PH_DATA;
			end
			PH_DATA: begin
				if (count_d == len_q) begin
					// checksum byte ends the frame either way
					if (xor_d == b) begin
						out_d.status = xcsfp_pkg::ST_GOOD;
						if (cmd_q == hb_code_q && len_q == xcsfp_pkg::HEARTBEAT_LEN) begin
							out_d.heartbeat_valid = 1'b1;
							out_d.heartbeat_word  = first_word_q;
						end
					end else begin
						out_d.status = xcsfp_pkg::ST_BAD;
					end
					phase_d = PH_HUNT;
					xor_d   = 8'd0;
					count_d = 8'd0;
				end else begin
					out_d.status       = xcsfp_pkg::ST_PAYLOAD;
					out_d.byte_index   = count_d;
					out_d.payload_byte = b;
					if (count_d[7:2] == 6'd0) begin
						first_word_d = first_word_q | ({24'd0, b} << {count_d[1:0], 3'b000});
					end
					xor_d   = xor_d ^ b;
					count_d = count_d + 8'd1;
				end
			end
			default: begin
				// unused phase codes drop the byte
				phase_d = PH_HUNT;
				xor_d   = 8'd0;
				count_d = 8'd0;
			end
		endcase

		out_d.command = cmd_d;
		out_d.length  = len_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			xor_q        <= 8'd0;
			count_q      <= 8'd0;
			cmd_q        <= 8'd0;
			len_q        <= 8'd0;
			first_word_q <= 32'd0;
		end else if (take) begin
			phase_q      <= phase_d;
			xor_q        <= xor_d;
			count_q      <= count_d;
			cmd_q        <= cmd_d;
			len_q        <= len_d;
			first_word_q <= first_word_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= out_d;
		end
	end

	assign res.valid           = out_valid_q;
	assign res.status          = out_q.status;
	assign res.command         = out_q.command;
	assign res.length          = out_q.length;
	assign res.byte_index      = out_q.byte_index;
	assign res.payload_byte    = out_q.payload_byte;
	assign res.heartbeat_valid = out_q.heartbeat_valid;
	assign res.heartbeat_word  = out_q.heartbeat_word;

	// a payload word always lies inside the frame length
	a_payload_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status == xcsfp_pkg::ST_PAYLOAD |-> res.byte_index < res.length)
		else $error("payload index beyond frame length");

	// heartbeat report only on a good frame of length four
	a_heartbeat_good: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.heartbeat_valid |->
			res.status == xcsfp_pkg::ST_GOOD && res.length == xcsfp_pkg::HEARTBEAT_LEN)
		else $error("heartbeat outside a good frame");

	// a frame end always leaves the parser hunting
	a_end_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		take && (out_d.status == xcsfp_pkg::ST_GOOD || out_d.status == xcsfp_pkg::ST_BAD)
			|=> phase_q == PH_HUNT && count_q == 8'd0 && xor_q == 8'd0)
		else $error("parser not hunting after frame end");

	// payload count never runs past the frame length while data is expected
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> count_q <= len_q)
		else $error("payload count past frame length");

endmodule
